[design/midi_bp_pkg.sv]
// Package for the MIDI byte parser with clock ticks.
// Holds the beat types, parser state type, opcodes and system byte codes.
// No dependencies; used by midi_bp_step and the top level.
package midi_bp_pkg;

  // Input operations
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_EOP  = 2'd1;
  localparam logic [1:0] OP_IDLE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // System bytes, top bit removed
  localparam logic [6:0] SYS_CLOCK  = 7'h78;
  localparam logic [6:0] SYS_SENSE  = 7'h7e;
  localparam logic [6:0] SYS_START  = 7'h7a;
  localparam logic [6:0] SYS_STOP   = 7'h7c;
  localparam logic [6:0] SYS_SX_BEG = 7'h70;
  localparam logic [6:0] SYS_SX_END = 7'h77;

  // Data position codes
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_NONE   = 2'd2;

  // Tick accumulator
  localparam int          TICK_UNIT     = 10000;
  localparam logic [15:0] CLOCK_STEP    = 16'd26666;
  localparam logic [15:0] TICK_STEP_RST = 16'd12800;
  localparam int          MAX_WHOLE     = 7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] midi_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] status_code;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [2:0] tick_count;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  held_status;
    logic [6:0]  held_first_data;
    logic [1:0]  data_position;
    logic        in_sysex;
    logic [13:0] tick_remainder;
  } parser_state_t;

endpackage

[design/midi_bp_step.sv]
// Next-state and result logic of the MIDI byte parser for one beat.
// Purely combinational; depends on midi_bp_pkg.
module midi_bp_step (
  input  midi_bp_pkg::in_item_t      item,
  input  midi_bp_pkg::parser_state_t cur,
  input  logic [15:0]                tick_step,
  output midi_bp_pkg::parser_state_t nxt,
  output midi_bp_pkg::out_item_t     res,
  output logic                       res_valid
);

  logic [6:0]  sys;
  logic [15:0] amount;
  logic [16:0] sum;
  logic [2:0]  whole;
  logic [16:0] whole_part;
  logic [13:0] new_rem;

  // Tick accumulator: sum stays below 8 units, so a compare chain finds the quotient
  always_comb begin
    sys    = item.midi_byte[6:0];
    amount = (item.operation == midi_bp_pkg::OP_BYTE) ? midi_bp_pkg::CLOCK_STEP : tick_step;
    sum    = {3'd0, cur.tick_remainder} + {1'b0, amount};
    whole  = 3'd0;
    for (int k = 1; k <= midi_bp_pkg::MAX_WHOLE; k++) begin
      if (sum >= 17'(k * midi_bp_pkg::TICK_UNIT)) begin
        whole = 3'(k);
      end
    end
    whole_part = 17'(whole) * 17'(midi_bp_pkg::TICK_UNIT);
    new_rem    = 14'(sum - whole_part);
  end

  // Operation decode
  always_comb begin
    nxt       = cur;
    res       = '0;
    res_valid = 1'b0;
    case (item.operation)
      midi_bp_pkg::OP_BYTE: begin
        if (item.midi_byte[7]) begin
          case (sys)
            midi_bp_pkg::SYS_CLOCK: begin
              nxt.tick_remainder = new_rem;
              res.kind           = midi_bp_pkg::KIND_TICK;
              res.tick_count     = whole;
              res_valid          = (whole != 3'd0);
            end
            midi_bp_pkg::SYS_SENSE: ;
            midi_bp_pkg::SYS_START: begin
              res.kind  = midi_bp_pkg::KIND_START;
              res_valid = 1'b1;
            end
            midi_bp_pkg::SYS_STOP: begin
              res.kind  = midi_bp_pkg::KIND_STOP;
              res_valid = 1'b1;
            end
            midi_bp_pkg::SYS_SX_BEG: nxt.in_sysex = 1'b1;
            midi_bp_pkg::SYS_SX_END: nxt.in_sysex = 1'b0;
            default: begin
              // New status flushes any pending message
              res.kind            = midi_bp_pkg::KIND_MSG;
              res.status_code     = cur.held_status;
              res.first_data      = cur.held_first_data;
              res_valid           = (cur.data_position != midi_bp_pkg::POS_NONE);
              nxt.held_status     = sys;
              nxt.held_first_data = 7'd0;
              nxt.data_position   = midi_bp_pkg::POS_FIRST;
            end
          endcase
        end else if (!cur.in_sysex) begin
          if (cur.data_position == midi_bp_pkg::POS_FIRST) begin
            nxt.held_first_data = sys;
            nxt.data_position   = midi_bp_pkg::POS_SECOND;
          end else if (cur.data_position == midi_bp_pkg::POS_SECOND) begin
            res.kind          = midi_bp_pkg::KIND_MSG;
            res.status_code   = cur.held_status;
            res.first_data    = cur.held_first_data;
            res.second_data   = sys;
            res_valid         = 1'b1;
            nxt.data_position = midi_bp_pkg::POS_NONE;
          end
        end
      end
      midi_bp_pkg::OP_EOP: begin
        // Report pending message, keep it pending
        res.kind        = midi_bp_pkg::KIND_MSG;
        res.status_code = cur.held_status;
        res.first_data  = cur.held_first_data;
        res_valid       = (cur.data_position != midi_bp_pkg::POS_NONE);
      end
      midi_bp_pkg::OP_IDLE: begin
        nxt.tick_remainder = new_rem;
        res.kind           = midi_bp_pkg::KIND_TICK;
        res.tick_count     = whole;
        res_valid          = (whole != 3'd0);
      end
      default: ;
    endcase
  end

endmodule

[design/midi_bp_pkg_unused_guard.sv]
// Result register stage of the MIDI byte parser: holds one result beat
// until the sink takes it. Depends on midi_bp_pkg.
module midi_bp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  midi_bp_pkg::out_item_t load_data,
  input  logic                   take,
  output logic                   valid,
  output midi_bp_pkg::out_item_t data
);

  logic                   valid_r, valid_nxt;
  midi_bp_pkg::out_item_t data_r;

  // Valid flag: set on load, cleared when taken without a new load
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

[design/midi_byte_parser_with_clock_ticks_top.sv]
// Top level of the MIDI byte parser with clock ticks.
// Depends on midi_bp_pkg, midi_bp_step and midi_bp_out_reg.
//
// One beat is taken per cycle while the input register is free or its beat
// moves on. A beat enters an input register, is decoded in the next cycle
// against the parser state, and any result lands in the output register.
// The state update and result are a single short pass through one decode
// block and a seven-way compare for whole ticks; the output register frees
// the input side whenever its result is taken in the same cycle, or when the
// beat yields no result. tick_step is written with cfg_we and takes effect
// for the next idle period; write it only while the block is idle.
module midi_byte_parser_with_clock_ticks_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  midi_bp_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output midi_bp_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata
);

  logic                       in_v_r;
  midi_bp_pkg::in_item_t      in_d_r;
  midi_bp_pkg::parser_state_t st_r;
  midi_bp_pkg::parser_state_t st_nxt;
  logic [15:0]                tick_step_r;
  midi_bp_pkg::out_item_t     res;
  logic                       res_valid;
  logic                       advance;
  logic                       out_v;

  // Decode of the held beat
  midi_bp_step u_step (
    .item      (in_d_r),
    .cur       (st_r),
    .tick_step (tick_step_r),
    .nxt       (st_nxt),
    .res       (res),
    .res_valid (res_valid)
  );

  // Held beat moves on when its result has room, or it has no result
  assign advance  = in_v_r && (!out_v || out_ready || !res_valid);
  assign in_ready = !in_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
  end

  // Parser state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.held_status     <= 7'd0;
      st_r.held_first_data <= 7'd0;
      st_r.data_position   <= midi_bp_pkg::POS_NONE;
      st_r.in_sysex        <= 1'b0;
      st_r.tick_remainder  <= 14'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= midi_bp_pkg::TICK_STEP_RST;
    end else if (cfg_we) begin
      tick_step_r <= cfg_wdata;
    end
  end

  // Result register
  midi_bp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .take      (out_ready),
    .valid     (out_v),
    .data      (out_data)
  );

  assign out_valid = out_v;

endmodule

[tb/midi_byte_parser_with_clock_ticks_top_test.sv]
// Self-checking testbench for midi_byte_parser_with_clock_ticks_top.
// Sends MIDI beats through a parser model kept in the bench and checks every result beat.
// Depends on midi_bp_pkg and the top level RTL only.
module midi_byte_parser_with_clock_ticks_top_test;

  localparam logic [1:0] OP_VOID = 2'd3;  // undefined operation, must be ignored
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  midi_bp_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_ready;
  midi_bp_pkg::out_item_t out_data;
  logic                   cfg_we;
  logic [15:0]            cfg_wdata;

  midi_byte_parser_with_clock_ticks_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Parser model state, mirrors the block
  logic [6:0]  mdl_status;
  logic [6:0]  mdl_first;
  logic [1:0]  mdl_pos;
  logic        mdl_sysex;
  logic [13:0] mdl_rem;
  logic [15:0] mdl_step;
  midi_bp_pkg::out_item_t pending_results[$];

  int err_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int step_writes = 0;
  int kind_seen[4];
  bit gaps_on = 1'b1;
  int burst_left = 1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [15:0] rx_pattern;
  logic [5:0]  rx_phase;
  logic        rx_open;

  function automatic midi_bp_pkg::out_item_t make_result(logic [1:0] kind, logic [6:0] st,
                                                         logic [6:0] d0, logic [6:0] d1,
                                                         logic [2:0] tc);
    midi_bp_pkg::out_item_t r;
    r.kind        = kind;
    r.status_code = st;
    r.first_data  = d0;
    r.second_data = d1;
    r.tick_count  = tc;
    return r;
  endfunction

  // Add to the tick accumulator; true when a whole tick was crossed
  function automatic bit add_ticks(int unsigned amount, output midi_bp_pkg::out_item_t r);
    int unsigned sum;
    int unsigned whole;
    sum     = mdl_rem + amount;
    whole   = sum / midi_bp_pkg::TICK_UNIT;
    mdl_rem = 14'(sum % midi_bp_pkg::TICK_UNIT);
    r = make_result(midi_bp_pkg::KIND_TICK, 7'd0, 7'd0, 7'd0, 3'(whole));
    return whole != 0;
  endfunction

  // Advance the model by one beat; true when the beat yields a result
  function automatic bit parse_beat(midi_bp_pkg::in_item_t b,
                                    output midi_bp_pkg::out_item_t r);
    logic [6:0] code;
    bit hit;
    code = b.midi_byte[6:0];
    hit  = 1'b0;
    // default result is a flush of the held message
    r = make_result(midi_bp_pkg::KIND_MSG, mdl_status, mdl_first, 7'd0, 3'd0);
    case (b.operation)
      midi_bp_pkg::OP_IDLE: hit = add_ticks(mdl_step, r);
      midi_bp_pkg::OP_EOP:  hit = (mdl_pos != midi_bp_pkg::POS_NONE);
      midi_bp_pkg::OP_BYTE: begin
        if (b.midi_byte[7]) begin
          case (code)
            midi_bp_pkg::SYS_CLOCK:  hit = add_ticks(midi_bp_pkg::CLOCK_STEP, r);
            midi_bp_pkg::SYS_SENSE:  hit = 1'b0;
            midi_bp_pkg::SYS_START: begin
              r   = make_result(midi_bp_pkg::KIND_START, 7'd0, 7'd0, 7'd0, 3'd0);
              hit = 1'b1;
            end
            midi_bp_pkg::SYS_STOP: begin
              r   = make_result(midi_bp_pkg::KIND_STOP, 7'd0, 7'd0, 7'd0, 3'd0);
              hit = 1'b1;
            end
            midi_bp_pkg::SYS_SX_BEG: mdl_sysex = 1'b1;
            midi_bp_pkg::SYS_SX_END: mdl_sysex = 1'b0;
            default: begin
              hit        = (mdl_pos != midi_bp_pkg::POS_NONE);
              mdl_status = code;
              mdl_first  = 7'd0;
              mdl_pos    = midi_bp_pkg::POS_FIRST;
            end
          endcase
        end else if (!mdl_sysex) begin
          if (mdl_pos == midi_bp_pkg::POS_FIRST) begin
            mdl_first = code;
            mdl_pos   = midi_bp_pkg::POS_SECOND;
          end else if (mdl_pos == midi_bp_pkg::POS_SECOND) begin
            r.second_data = code;
            hit           = 1'b1;
            mdl_pos       = midi_bp_pkg::POS_NONE;
          end
        end
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] pick_status();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(8'h80, 8'hEF));
    return 8'($urandom_range(8'hF0, 8'hFF));
  endfunction

  // Offer one beat, wait for it to be taken, then maybe open a gap
  task automatic send_beat(logic [1:0] op, logic [7:0] value);
    midi_bp_pkg::in_item_t  beat;
    midi_bp_pkg::out_item_t r;
    int                     gap;
    beat.operation = op;
    beat.midi_byte = value;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    beats_sent++;
    if (parse_beat(beat, r)) pending_results.push_back(r);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic send_byte(logic [7:0] value);
    send_beat(midi_bp_pkg::OP_BYTE, value);
  endtask

  // Wait until every expected result is in and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_step = value;
    step_writes++;
  endtask

  // Directed: data extremes, each system byte, flushes, sysex rules, odd ops
  task automatic test_directed();
    send_byte(8'h90); send_byte(8'h00); send_byte(8'h7F);
    send_beat(midi_bp_pkg::OP_EOP, 8'h00);   // nothing pending
    send_byte(8'h40);                        // stray data byte
    send_byte(8'hB3); send_byte(8'h12);
    send_beat(midi_bp_pkg::OP_EOP, 8'hFF);   // flush, stays pending
    send_beat(midi_bp_pkg::OP_EOP, 8'h00);
    send_byte(8'h05);                        // completes held message
    send_byte(8'hC0); send_byte(8'hE1);      // flush with no data yet
    send_byte({1'b1, midi_bp_pkg::SYS_CLOCK});
    send_byte({1'b1, midi_bp_pkg::SYS_CLOCK});
    send_byte({1'b1, midi_bp_pkg::SYS_SENSE});
    send_byte({1'b1, midi_bp_pkg::SYS_START});
    send_byte({1'b1, midi_bp_pkg::SYS_STOP});
    send_byte({1'b1, midi_bp_pkg::SYS_SX_BEG});
    send_byte(8'h55);                        // swallowed
    send_byte(8'h80);                        // status inside sysex still flushes
    send_byte(8'h21);                        // swallowed
    send_byte({1'b1, midi_bp_pkg::SYS_SX_END});
    send_beat(OP_VOID, 8'hFF);
    send_beat(midi_bp_pkg::OP_IDLE, 8'hA5);
    send_byte(8'hFF); send_byte(8'h7F);
    send_beat(midi_bp_pkg::OP_EOP, 8'h00);
    settle();
  endtask

  // Tick accumulator under a range of tick_step settings
  task automatic test_tick_steps();
    logic [15:0] steps[7];
    steps = '{16'd0, 16'hFFFF, 16'd1, 16'd9999, 16'd10000, 16'($urandom),
              midi_bp_pkg::TICK_STEP_RST};
    foreach (steps[i]) begin
      write_tick_step(steps[i]);
      repeat (10) begin
        case ($urandom_range(0, 5))
          0:       send_byte({1'b1, midi_bp_pkg::SYS_CLOCK});
          1:       send_byte({1'b1, midi_bp_pkg::SYS_SENSE});
          default: send_beat(midi_bp_pkg::OP_IDLE, 8'($urandom));
        endcase
      end
    end
    settle();
  endtask

  // Mostly well-formed channel messages with random content and realtime mixed in
  task automatic test_messages(int count);
    int stop_at;
    int n_data;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      send_byte(pick_status());
      n_data = $urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 3);
      repeat (n_data) begin
        if ($urandom_range(0, 9) == 0) send_byte({1'b1, midi_bp_pkg::SYS_CLOCK});
        send_byte(8'($urandom_range(0, 127)));
      end
      case ($urandom_range(0, 9))
        0: send_beat(midi_bp_pkg::OP_EOP, 8'($urandom));
        1: send_beat(midi_bp_pkg::OP_IDLE, 8'($urandom));
        2: send_byte({1'b1, ($urandom_range(0, 1) != 0) ? midi_bp_pkg::SYS_START
                                                         : midi_bp_pkg::SYS_STOP});
        default: ;
      endcase
    end
    settle();
  endtask

  // Sysex frames, some broken by channel status or missing an end
  task automatic test_sysex(int count);
    int stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 1) != 0) begin
        send_byte(pick_status());
        send_byte(8'($urandom_range(0, 127)));
      end
      send_byte({1'b1, midi_bp_pkg::SYS_SX_BEG});
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0:       send_byte({1'b1, midi_bp_pkg::SYS_CLOCK});
          1:       send_byte(pick_status());
          2:       send_beat(midi_bp_pkg::OP_EOP, 8'($urandom));
          default: send_byte(8'($urandom_range(0, 127)));
        endcase
      end
      if ($urandom_range(0, 4) != 0) send_byte({1'b1, midi_bp_pkg::SYS_SX_END});
      send_byte(8'($urandom_range(0, 127)));
    end
    settle();
  endtask

  // Fully random beats, every operation and byte value
  task automatic test_noise(int count);
    repeat (count) send_beat(2'($urandom_range(0, 3)), 8'($urandom));
    settle();
  endtask

  // Receiver holds off while the sender keeps offering result-heavy beats
  task automatic test_backpressure(int count);
    int stop_at;
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 2))
        0: send_byte({1'b1, midi_bp_pkg::SYS_START});
        1: send_byte({1'b1, midi_bp_pkg::SYS_STOP});
        default: begin
          send_byte(pick_status());
          send_byte(8'($urandom_range(0, 127)));
          send_byte(8'($urandom_range(0, 127)));
        end
      endcase
    end
    gaps_on = 1'b1;
    settle();
  endtask

  // Receiver: long hold on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_pattern <= 16'hA5F3;
      rx_phase   <= '0;
      rx_open    <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_pattern[0] | rx_open;
      rx_phase  <= rx_phase + 1'b1;
      if (rx_phase == '1) begin
        rx_pattern <= 16'($urandom) | 16'h0001;
        rx_open    <= ($urandom_range(0, 3) == 0);
      end else begin
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
    end
  end

  // Result check: sampled mid-cycle, the beat is taken at the next edge
  always @(negedge clk) begin : check_results
    midi_bp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      kind_seen[out_data.kind]++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: exp no result beat, got kind %0d st %h d0 %h d1 %h tc %0d",
                 $time, out_data.kind, out_data.status_code, out_data.first_data,
                 out_data.second_data, out_data.tick_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind || out_data.status_code !== want.status_code ||
            out_data.first_data !== want.first_data ||
            out_data.second_data !== want.second_data ||
            out_data.tick_count !== want.tick_count) begin
          err_count++;
          $display("%0t: mismatch exp kind %0d st %h d0 %h d1 %h tc %0d",
                   $time, want.kind, want.status_code, want.first_data,
                   want.second_data, want.tick_count);
          $display("%0t:          got kind %0d st %h d0 %h d1 %h tc %0d",
                   $time, out_data.kind, out_data.status_code, out_data.first_data,
                   out_data.second_data, out_data.tick_count);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    mdl_status = '0;
    mdl_first  = '0;
    mdl_pos    = midi_bp_pkg::POS_NONE;
    mdl_sysex  = 1'b0;
    mdl_rem    = '0;
    mdl_step   = midi_bp_pkg::TICK_STEP_RST;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_tick_steps();
    test_messages(200);
    test_sysex(100);
    write_tick_step(16'($urandom));
    test_noise(100);
    test_backpressure(60);
    write_tick_step(16'hFFFF);
    test_noise(20);

    $display("Covered %0d beats and %0d results: msg %0d, tick %0d, start %0d, stop %0d",
             beats_sent, results_seen, kind_seen[midi_bp_pkg::KIND_MSG],
             kind_seen[midi_bp_pkg::KIND_TICK], kind_seen[midi_bp_pkg::KIND_START],
             kind_seen[midi_bp_pkg::KIND_STOP]);
    $display("tick_step written %0d times, one long receiver hold, %0d errors",
             step_writes, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
